// ===== rtl/srfr_pkg.sv =====
package srfr_pkg;

	localparam logic [7:0] START_CODE   = 8'hFF;
	localparam int         PAYLOAD_LEN  = 6;
	localparam int         COUNT_W      = $clog2(PAYLOAD_LEN + 1);
	localparam logic [7:0] CMD_RESET    = 8'd134;

	// Register word indexes on the configuration port.
	localparam logic REG_EXPECTED_COMMAND = 1'b0;

	typedef logic [PAYLOAD_LEN-1:0][7:0] payload_t;

	// Parser phase, one-hot.
	typedef enum logic [3:0] {
		PH_HUNT  = 4'b0001,
		PH_CMD   = 4'b0010,
		PH_DATA  = 4'b0100,
		PH_CHECK = 4'b1000
	} phase_t;

	// One result word as it leaves the parser.
	typedef struct packed {
		logic     frame_end;
		logic     frame_good;
		payload_t payload;
	} result_t;

endpackage

// ===== rtl/srfr_cfg.sv =====
module srfr_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  expected_command
);
	import srfr_pkg::*;

	logic [7:0] cmd_q;
	logic       wr_en;
	logic       hit;

	assign pready = 1'b1;
	assign hit    = (paddr[2] == REG_EXPECTED_COMMAND);
	assign wr_en  = psel & penable & pwrite & pready & hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= CMD_RESET;
		end else if (wr_en) begin
			cmd_q <= pwdata[7:0];
		end
	end

	assign prdata           = hit ? {24'd0, cmd_q} : 32'd0;
	assign expected_command = cmd_q;

endmodule

// ===== rtl/srfr_parser.sv =====
module srfr_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        rx_byte,
	input  logic [7:0]        expected_command,
	output srfr_pkg::result_t result
);
	import srfr_pkg::*;

	phase_t               phase_q,  phase_d;
	logic [COUNT_W-1:0]   count_q,  count_d;
	logic [7:0]           sum_q,    sum_d;
	payload_t             store_q,  store_d;
	logic [7:0]           sum_add;
	logic [COUNT_W-1:0]   count_inc;

	assign sum_add   = sum_q + rx_byte;
	assign count_inc = count_q + COUNT_W'(1);

	always_comb begin
		phase_d           = phase_q;
		count_d           = count_q;
		sum_d             = sum_add;
		store_d           = store_q;
		result.frame_end  = 1'b0;
		result.frame_good = 1'b0;
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == START_CODE) begin
					sum_d   = 8'd0;
					phase_d = PH_CMD;
				end
			end
			PH_CMD: begin
				if (rx_byte == expected_command) begin
					count_d = '0;
					phase_d = PH_DATA;
				end else if (rx_byte == START_CODE) begin
					// A mismatching 0xFF may itself open a new frame.
					sum_d   = 8'd0;
					phase_d = PH_CMD;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_DATA: begin
				if (count_q < COUNT_W'(PAYLOAD_LEN)) begin
					store_d[count_q] = rx_byte;
				end
				count_d = count_inc;
				if (count_inc >= COUNT_W'(PAYLOAD_LEN)) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				phase_d           = PH_HUNT;
				result.frame_end  = 1'b1;
				result.frame_good = (sum_add == 8'd0);
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
		result.payload = store_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			sum_q   <= 8'd0;
			store_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			count_q <= count_d;
			sum_q   <= sum_d;
			store_q <= store_d;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(PAYLOAD_LEN))
		else $error("payload count out of range");

	a_check_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CHECK) |-> (count_q == COUNT_W'(PAYLOAD_LEN)))
		else $error("check phase reached without a full payload");

	a_end_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && result.frame_end) |=> (phase_q == PH_HUNT))
		else $error("parser did not return to hunting after frame end");

endmodule

// ===== rtl/sensor_reply_frame_receiver_top.sv =====
// Receiver for nine-byte sensor reply frames. Each accepted input word is one
// received byte, and every byte yields exactly one registered result word.
// A frame is a 0xFF start byte, a command byte that must equal the
// expected_command register (byte address 0, reset value 0x86), six payload
// bytes and a check byte. The frame is good when the 8-bit sum of all bytes
// after the start byte, check byte included, is zero. A result carries
// frame_end (set on the check byte), frame_good (set only with frame_end)
// and the six payload bytes as stored after that byte, so between frames
// they repeat the last payload. When the command byte does not match, the
// same byte is looked at again as a possible start byte. The block sustains
// one byte per clock: the parser updates its state in the cycle a byte is
// accepted, and its result goes into a two-word output buffer. The input is
// stalled only while the second buffer word is occupied, which starts when a
// word arrives behind a stalled output and lasts until the cycle in which the
// output takes its current word and the held word moves up.
// Write expected_command only while the block is idle.
module sensor_reply_frame_receiver_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        frame_end,
	output logic        frame_good,
	output logic [7:0]  payload_0,
	output logic [7:0]  payload_1,
	output logic [7:0]  payload_2,
	output logic [7:0]  payload_3,
	output logic [7:0]  payload_4,
	output logic [7:0]  payload_5,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import srfr_pkg::*;

	logic       in_acc;
	logic       out_fire;
	logic [7:0] expected_command;
	result_t    new_res;

	// Main output word and the skid word behind it.
	logic       out_valid_q;
	result_t    out_res_q;
	logic       skid_valid_q;
	result_t    skid_res_q;

	srfr_cfg u_cfg (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.expected_command (expected_command)
	);

	srfr_parser u_parser (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (in_acc),
		.rx_byte          (rx_byte),
		.expected_command (expected_command),
		.result           (new_res)
	);

	// The input stalls only when the skid word is occupied, which is a
	// registered condition, so the stall never depends on this cycle's valid.
	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid & ~in_stall;
	assign out_fire = out_valid_q & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_fire || !out_valid_q) begin
			// The main word is free: the skid word moves up first, else a new word.
			out_valid_q  <= skid_valid_q | in_acc;
			skid_valid_q <= 1'b0;
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire || !out_valid_q) begin
			if (skid_valid_q) begin
				out_res_q <= skid_res_q;
			end else if (in_acc) begin
				out_res_q <= new_res;
			end
		end else if (in_acc) begin
			skid_res_q <= new_res;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_end  = out_res_q.frame_end;
	assign frame_good = out_res_q.frame_good;
	assign payload_0  = out_res_q.payload[0];
	assign payload_1  = out_res_q.payload[1];
	assign payload_2  = out_res_q.payload[2];
	assign payload_3  = out_res_q.payload[3];
	assign payload_4  = out_res_q.payload[4];
	assign payload_5  = out_res_q.payload[5];

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held while main output word is empty");

	a_good_needs_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_res_q.frame_good || out_res_q.frame_end))
		else $error("good flag shown without frame end");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && !skid_valid_q && in_acc) |=> skid_valid_q)
		else $error("accepted word not kept while output is stalled");

endmodule
